>>> design/small_matrix_add_sub_multiply_defines.svh
// ----------------------------------------------------------------------------
// Small matrix add/sub/multiply: assertion macros
// Shared assertion macros for the matrix unit; they vanish under synthesis.
// ----------------------------------------------------------------------------
`ifndef SMALL_MATRIX_ADD_SUB_MULTIPLY_DEFINES_SVH
`define SMALL_MATRIX_ADD_SUB_MULTIPLY_DEFINES_SVH

`ifndef SYNTHESIS
`define SMASM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SMASM_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SMASM_ASSERT(lbl, clk, rst_n, prop, msg)
`define SMASM_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

>>> design/smasm_pkg.sv
// ----------------------------------------------------------------------------
// Small matrix add/sub/multiply: package
// Sizes, codes, shared types and helper functions of the matrix unit.
// ----------------------------------------------------------------------------
package smasm_pkg;

  localparam int MAX_DIM    = 8;
  localparam int ELEM_W     = 16;
  localparam int IDX_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W      = $clog2(MAX_DIM + 1);
  localparam int DEPTH      = MAX_DIM * MAX_DIM;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int ACC_W      = 40;
  localparam int FRAC_SHIFT = 8;

  localparam int ROW_W      = 3;
  localparam int VALUE_W    = 16;
  localparam int FUNC_W     = 2;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 48;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;
  localparam int DIMREG_W   = 4;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_SUB    = 2'd1;
  localparam logic [1:0] OP_MUL    = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [FUNC_W-1:0] FUNC_WR_A    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WR_B    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_OP_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_ROWS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A_COLS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B_ROWS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_B_COLS  = 3'd4;

  localparam logic [DIMREG_W-1:0] DIM_RESET = 4'd8;

  typedef struct packed {
    logic [1:0]          op_mode;
    logic [DIMREG_W-1:0] a_rows;
    logic [DIMREG_W-1:0] a_cols;
    logic [DIMREG_W-1:0] b_rows;
    logic [DIMREG_W-1:0] b_cols;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic       first;
    logic       last;
    logic [1:0] mode;
  } mac_ctrl_t;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIMREG_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (int'(d) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(d);
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] elem_addr(int unsigned r, int unsigned c);
    return ADDR_W'(r * MAX_DIM + c);
  endfunction

endpackage

>>> design/smasm_ram.sv
// ----------------------------------------------------------------------------
// Small matrix add/sub/multiply: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module smasm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> design/smasm_mac.sv
// ----------------------------------------------------------------------------
// Small matrix add/sub/multiply: shared arithmetic unit
// Forms one term per cycle (sum, difference or product of two elements) and
// accumulates the terms of one result element in a 40-bit register.
// ----------------------------------------------------------------------------
module smasm_mac (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  smasm_pkg::mac_ctrl_t             ctrl_i,
  input  logic signed [smasm_pkg::ELEM_W-1:0] a_i,
  input  logic signed [smasm_pkg::ELEM_W-1:0] b_i,
  output logic [smasm_pkg::ACC_W-1:0]      acc_o,
  output logic                             done_o
);

  smasm_pkg::mac_ctrl_t s1_q, s2_q;
  logic signed [smasm_pkg::ACC_W-1:0]    term_d, term_q;
  logic signed [smasm_pkg::ELEM_W:0]     sum;
  logic signed [2*smasm_pkg::ELEM_W-1:0] prod;
  logic [smasm_pkg::ACC_W-1:0]           acc_d, acc_q;
  logic                                  done_q;

  always_comb begin
    sum  = (s1_q.mode == smasm_pkg::OP_SUB) ? (a_i - b_i) : (a_i + b_i);
    prod = a_i * b_i;
    case (s1_q.mode)
      smasm_pkg::OP_ADD,
      smasm_pkg::OP_SUB: term_d = smasm_pkg::ACC_W'(sum) <<< smasm_pkg::FRAC_SHIFT;
      smasm_pkg::OP_MUL: term_d = smasm_pkg::ACC_W'(prod);
      default:           term_d = '0;
    endcase
  end

  always_comb begin
    acc_d = acc_q;
    if (s2_q.valid) begin
      acc_d = s2_q.first ? term_q : (acc_q + term_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= '0;
      s2_q   <= '0;
      acc_q  <= '0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= ctrl_i;
      s2_q   <= s1_q;
      acc_q  <= acc_d;
      done_q <= s2_q.valid && s2_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    term_q <= term_d;
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule

>>> design/smasm_seq.sv
// ----------------------------------------------------------------------------
// Small matrix add/sub/multiply: sequencer
// Checks shapes, walks the result elements and their terms, drives the store
// read addresses and the shared unit, and holds the result register.
// ----------------------------------------------------------------------------
`include "small_matrix_add_sub_multiply_defines.svh"

module smasm_seq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  smasm_pkg::cfg_t                 cfg_i,
  input  logic                            in_valid_i,
  input  logic [smasm_pkg::FUNC_W-1:0]    in_func_i,
  output logic                            in_ready_o,
  output logic [smasm_pkg::ADDR_W-1:0]    raddr_a_o,
  output logic [smasm_pkg::ADDR_W-1:0]    raddr_b_o,
  output smasm_pkg::mac_ctrl_t            mac_ctrl_o,
  input  logic [smasm_pkg::ACC_W-1:0]     mac_acc_i,
  input  logic                            mac_done_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [smasm_pkg::ROW_W-1:0]     out_row_o,
  output logic [smasm_pkg::ROW_W-1:0]     out_col_o,
  output logic [smasm_pkg::ACC_W-1:0]     out_result_o,
  output logic                            out_status_o,
  output logic                            out_last_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_PUSH  = 2'd3;

  logic [1:0]                  state_d, state_q;
  logic [smasm_pkg::IDX_W-1:0] i_d, i_q, j_d, j_q, k_d, k_q;
  logic [smasm_pkg::DIM_W-1:0] rows_d, rows_q, cols_d, cols_q, kn_d, kn_q;
  logic [1:0]                  mode_d, mode_q;
  logic                        err_d, err_q;
  logic [smasm_pkg::DIM_W-1:0] ar, ac, br, bc;
  logic                        accept, mismatch, is_mul, k_last, row_last, col_last;
  logic                        out_free, out_load, out_last;

  logic                        out_valid_q, out_status_q, out_last_q;
  logic [smasm_pkg::ROW_W-1:0] out_row_q, out_col_q;
  logic [smasm_pkg::ACC_W-1:0] out_result_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign ar = smasm_pkg::clamp_dim(cfg_i.a_rows);
  assign ac = smasm_pkg::clamp_dim(cfg_i.a_cols);
  assign br = smasm_pkg::clamp_dim(cfg_i.b_rows);
  assign bc = smasm_pkg::clamp_dim(cfg_i.b_cols);
  assign is_mul   = (cfg_i.op_mode == smasm_pkg::OP_MUL);
  assign mismatch = is_mul ? (ac != br) : ((ar != br) || (ac != bc));

  assign k_last   = (mode_q != smasm_pkg::OP_MUL) ||
                    ((smasm_pkg::DIM_W'(k_q) + smasm_pkg::DIM_W'(1)) == kn_q);
  assign row_last = (smasm_pkg::DIM_W'(i_q) + smasm_pkg::DIM_W'(1)) == rows_q;
  assign col_last = (smasm_pkg::DIM_W'(j_q) + smasm_pkg::DIM_W'(1)) == cols_q;
  assign out_last = err_q || (row_last && col_last);

  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = (state_q == ST_PUSH) && out_free;

  always_comb begin
    mac_ctrl_o.valid = (state_q == ST_ISSUE);
    mac_ctrl_o.first = (k_q == '0);
    mac_ctrl_o.last  = k_last;
    mac_ctrl_o.mode  = mode_q;
    if (mode_q == smasm_pkg::OP_MUL) begin
      raddr_a_o = smasm_pkg::elem_addr(int'(i_q), int'(k_q));
      raddr_b_o = smasm_pkg::elem_addr(int'(k_q), int'(j_q));
    end else begin
      raddr_a_o = smasm_pkg::elem_addr(int'(i_q), int'(j_q));
      raddr_b_o = smasm_pkg::elem_addr(int'(i_q), int'(j_q));
    end
  end

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    rows_d  = rows_q;
    cols_d  = cols_q;
    kn_d    = kn_q;
    mode_d  = mode_q;
    err_d   = err_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (in_func_i == smasm_pkg::FUNC_COMPUTE) &&
            (cfg_i.op_mode != smasm_pkg::OP_UNUSED)) begin
          mode_d = cfg_i.op_mode;
          i_d    = '0;
          j_d    = '0;
          k_d    = '0;
          rows_d = ar;
          cols_d = is_mul ? bc : ac;
          kn_d   = ac;
          err_d  = mismatch;
          state_d = mismatch ? ST_PUSH : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (k_last) begin
          k_d     = '0;
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + smasm_pkg::IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (mac_done_i) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          if (out_last) begin
            err_d   = 1'b0;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_ISSUE;
            if (col_last) begin
              j_d = '0;
              i_d = i_q + smasm_pkg::IDX_W'(1);
            end else begin
              j_d = j_q + smasm_pkg::IDX_W'(1);
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      rows_q      <= '0;
      cols_q      <= '0;
      kn_q        <= '0;
      mode_q      <= smasm_pkg::OP_ADD;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      rows_q  <= rows_d;
      cols_q  <= cols_d;
      kn_q    <= kn_d;
      mode_q  <= mode_d;
      err_q   <= err_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_row_q    <= err_q ? '0 : smasm_pkg::ROW_W'(i_q);
      out_col_q    <= err_q ? '0 : smasm_pkg::ROW_W'(j_q);
      out_result_q <= err_q ? '0 : mac_acc_i;
      out_status_q <= err_q;
      out_last_q   <= out_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_row_o    = out_row_q;
  assign out_col_o    = out_col_q;
  assign out_result_o = out_result_q;
  assign out_status_o = out_status_q;
  assign out_last_o   = out_last_q;

  `SMASM_ASSERT(a_done_in_drain, clk_i, rst_ni, mac_done_i |-> (state_q == ST_DRAIN), "Unit finished outside the drain state.")
  `SMASM_ASSERT(a_k_in_range, clk_i, rst_ni, (state_q == ST_ISSUE) |-> (smasm_pkg::DIM_W'(k_q) < kn_q), "Term index ran past the inner dimension.")
  `SMASM_ASSERT(a_err_result, clk_i, rst_ni, (out_valid_q && out_status_q) |-> ((out_result_q == '0) && out_last_q), "Shape error transaction is not a single zero result.")
  `SMASM_ASSERT(a_run_end_idle, clk_i, rst_ni, (out_load && out_last) |=> (state_q == ST_IDLE), "Sequencer did not return to idle after the final result.")
  `SMASM_ASSERT_NEVER(a_accept_busy, clk_i, rst_ni, accept && (state_q != ST_IDLE), "Input transaction taken while busy.")

endmodule

>>> design/small_matrix_add_sub_multiply.sv
// ----------------------------------------------------------------------------
// Small matrix add/sub/multiply: top level
// Loads A and B element by element and streams out A+B, A-B or A*B.
// ----------------------------------------------------------------------------
// A compute transaction emits one result per element, formed one element at a time
// through the single read port of each store and the one shared MAC unit; multiply
// accumulates a_cols terms for each element.
// A shape error gives a single result, with its status set.
// rst_ni idles control, sets add and 8x8 shapes and clears the accumulator only.
module small_matrix_add_sub_multiply (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [smasm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [smasm_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // row [2:0], col [5:3], value [21:6], zero fill [23:22]
  input  logic [smasm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // func [1:0]
  input  logic [smasm_pkg::FUNC_W-1:0]          s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // out_row [2:0], out_col [5:3], result [45:6], zero fill [47:46]
  output logic [smasm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // status [0]
  output logic [0:0]                            m_axis_tuser,
  output logic                                  m_axis_tlast
);

  smasm_pkg::cfg_t      cfg_q;
  smasm_pkg::mac_ctrl_t mac_ctrl;

  logic [smasm_pkg::ROW_W-1:0]   in_row, in_col;
  logic [smasm_pkg::ELEM_W-1:0]  in_value;
  logic                          in_accept, in_inside, we_a, we_b;
  logic [smasm_pkg::ADDR_W-1:0]  waddr, raddr_a, raddr_b;
  logic [smasm_pkg::ELEM_W-1:0]  rdata_a, rdata_b;
  logic [smasm_pkg::ACC_W-1:0]   mac_acc, out_result;
  logic                          mac_done;
  logic [smasm_pkg::ROW_W-1:0]   out_row, out_col;
  logic                          out_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.op_mode <= smasm_pkg::OP_ADD;
      cfg_q.a_rows  <= smasm_pkg::DIM_RESET;
      cfg_q.a_cols  <= smasm_pkg::DIM_RESET;
      cfg_q.b_rows  <= smasm_pkg::DIM_RESET;
      cfg_q.b_cols  <= smasm_pkg::DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        smasm_pkg::REG_OP_MODE: cfg_q.op_mode <= cfg_data_i[1:0];
        smasm_pkg::REG_A_ROWS:  cfg_q.a_rows  <= cfg_data_i;
        smasm_pkg::REG_A_COLS:  cfg_q.a_cols  <= cfg_data_i;
        smasm_pkg::REG_B_ROWS:  cfg_q.b_rows  <= cfg_data_i;
        smasm_pkg::REG_B_COLS:  cfg_q.b_cols  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_row    = s_axis_tdata[2:0];
  assign in_col    = s_axis_tdata[5:3];
  assign in_value  = s_axis_tdata[6 +: smasm_pkg::ELEM_W];
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign in_inside = (int'(in_row) < smasm_pkg::MAX_DIM) &&
                     (int'(in_col) < smasm_pkg::MAX_DIM);
  assign we_a  = in_accept && in_inside && (s_axis_tuser == smasm_pkg::FUNC_WR_A);
  assign we_b  = in_accept && in_inside && (s_axis_tuser == smasm_pkg::FUNC_WR_B);
  assign waddr = smasm_pkg::elem_addr(int'(in_row), int'(in_col));

  smasm_ram #(
    .WIDTH (smasm_pkg::ELEM_W),
    .DEPTH (smasm_pkg::DEPTH)
  ) u_store_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (in_value),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  smasm_ram #(
    .WIDTH (smasm_pkg::ELEM_W),
    .DEPTH (smasm_pkg::DEPTH)
  ) u_store_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (in_value),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  smasm_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (rdata_a),
    .b_i    (rdata_b),
    .acc_o  (mac_acc),
    .done_o (mac_done)
  );

  smasm_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid),
    .in_func_i    (s_axis_tuser),
    .in_ready_o   (s_axis_tready),
    .raddr_a_o    (raddr_a),
    .raddr_b_o    (raddr_b),
    .mac_ctrl_o   (mac_ctrl),
    .mac_acc_i    (mac_acc),
    .mac_done_i   (mac_done),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_row_o    (out_row),
    .out_col_o    (out_col),
    .out_result_o (out_result),
    .out_status_o (out_status),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_result, out_col, out_row};
  assign m_axis_tuser = out_status;

endmodule
